[rtl/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Types shared between the sequencer and the multiply-reduce unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

    typedef struct packed {
        logic busy;
        logic done;
    } mexp_mm_status_t;

endpackage

[rtl/modular_exponentiation.sv]
// For a nonzero modulus, one modular multiplication reduces the base, then one square per
//   exponent bit below the highest set bit and one multiply per set bit; the result then
//   passes the output register and may wait there for m_tready.
// One request at a time; the next is accepted from the cycle in which the result shows.
// Reset (aresetn low, synchronous) returns to idle and drops any pending result.
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Right-to-left square and multiply around one bit-serial multiply-reduce unit.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int MOD_BITS = 31,
    parameter int EXP_BITS = 63
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // base_value, exponent_value, modulus_value, zero pad
    input  logic [((2*MOD_BITS+EXP_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // power_residue, zero pad
    output logic [((MOD_BITS+7)/8)*8-1:0] m_tdata
);
    import mexp_pkg::*;

    localparam int OUT_W = ((MOD_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [EXP_BITS-1:0] exp_reg;
    logic [MOD_BITS-1:0] mod_reg;
    logic [MOD_BITS-1:0] acc_reg;
    logic [MOD_BITS-1:0] pw_reg;
    logic [MOD_BITS-1:0] res_reg;
    logic [MOD_BITS-1:0] out_reg;
    logic                out_valid_reg;
    logic                mm_start_reg;
    logic [MOD_BITS-1:0] mm_a_reg;
    logic [MOD_BITS-1:0] mm_b_reg;

    logic [MOD_BITS-1:0] in_base;
    logic [EXP_BITS-1:0] in_exp;
    logic [MOD_BITS-1:0] in_mod;
    logic [MOD_BITS-1:0] mm_result;
    mexp_mm_status_t     mm_stat;
    logic                s_fire;
    logic                mod_is_one;

    assign in_base    = s_tdata[MOD_BITS-1:0];
    assign in_exp     = s_tdata[MOD_BITS+EXP_BITS-1:MOD_BITS];
    assign in_mod     = s_tdata[2*MOD_BITS+EXP_BITS-1:MOD_BITS+EXP_BITS];
    assign mod_is_one = (in_mod == MOD_BITS'(1));

    assign s_tready = (state_reg == ST_IDLE) && !mm_stat.busy;
    assign s_fire   = s_tvalid && s_tready;

    mexp_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mm_start_reg),
        .op_a      (mm_a_reg),
        .op_b      (mm_b_reg),
        .op_m      (mod_reg),
        .result    (mm_result),
        .mm_status (mm_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mm_start_reg  <= 1'b0;
        end else begin
            if ((state_reg == ST_DONE) && (!out_valid_reg || m_tready)) begin
                out_reg       <= res_reg;
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        exp_reg <= in_exp;
                        mod_reg <= in_mod;
                        if (in_mod == '0) begin
                            res_reg      <= '0;
                            mm_start_reg <= 1'b0;
                            state_reg    <= ST_DONE;
                        end else begin
                            // reduce the base as base * 1 mod m (base * 0 when m is 1)
                            acc_reg      <= mod_is_one ? '0 : MOD_BITS'(1);
                            mm_a_reg     <= in_base;
                            mm_b_reg     <= mod_is_one ? '0 : MOD_BITS'(1);
                            mm_start_reg <= 1'b1;
                            state_reg    <= ST_BASE;
                        end
                    end else begin
                        mm_start_reg <= 1'b0;
                    end
                end
                ST_BASE, ST_SQR: begin
                    if (mm_stat.done) begin
                        pw_reg <= mm_result;
                        if (exp_reg == '0) begin
                            res_reg      <= acc_reg;
                            mm_start_reg <= 1'b0;
                            state_reg    <= ST_DONE;
                        end else if (exp_reg[0]) begin
                            mm_a_reg     <= acc_reg;
                            mm_b_reg     <= mm_result;
                            mm_start_reg <= 1'b1;
                            state_reg    <= ST_MUL;
                        end else begin
                            mm_a_reg     <= mm_result;
                            mm_b_reg     <= mm_result;
                            mm_start_reg <= 1'b1;
                            exp_reg      <= exp_reg >> 1;
                            state_reg    <= ST_SQR;
                        end
                    end else begin
                        mm_start_reg <= 1'b0;
                    end
                end
                ST_MUL: begin
                    if (mm_stat.done) begin
                        acc_reg <= mm_result;
                        if (exp_reg[EXP_BITS-1:1] == '0) begin
                            res_reg      <= mm_result;
                            mm_start_reg <= 1'b0;
                            state_reg    <= ST_DONE;
                        end else begin
                            mm_a_reg     <= pw_reg;
                            mm_b_reg     <= pw_reg;
                            mm_start_reg <= 1'b1;
                            exp_reg      <= exp_reg >> 1;
                            state_reg    <= ST_SQR;
                        end
                    end else begin
                        mm_start_reg <= 1'b0;
                    end
                end
                ST_DONE: begin
                    mm_start_reg <= 1'b0;
                    if (!out_valid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    mm_start_reg <= 1'b0;
                    state_reg    <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_reg);

endmodule

[rtl/mexp_mulmod.sv]
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved multiply and reduce: one bit of operand a per cycle, MSB first.
// Requires b < m; a may take any value. Result (a * b) mod m.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
    parameter int MOD_BITS = 31
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [MOD_BITS-1:0]      op_a,
    input  logic [MOD_BITS-1:0]      op_b,
    input  logic [MOD_BITS-1:0]      op_m,
    output logic [MOD_BITS-1:0]      result,
    output mexp_pkg::mexp_mm_status_t mm_status
);
    import mexp_pkg::*;

    localparam int CW = $clog2(MOD_BITS + 1);
    localparam int SW = MOD_BITS + 3;

    logic [MOD_BITS-1:0] a_reg;
    logic [MOD_BITS-1:0] b_reg;
    logic [MOD_BITS-1:0] m_reg;
    logic [MOD_BITS-1:0] r_reg;
    logic [MOD_BITS-1:0] r_next;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [SW-1:0] sum;
    logic [SW-1:0] diff1;
    logic [SW-1:0] diff2;

    // 2r + bit*b < 3m: subtract 2m or m in parallel
    always_comb begin
        sum   = (SW'(r_reg) << 1) + (a_reg[MOD_BITS-1] ? SW'(b_reg) : '0);
        diff1 = sum - SW'(m_reg);
        diff2 = sum - (SW'(m_reg) << 1);
        if (!diff2[SW-1]) begin
            r_next = diff2[MOD_BITS-1:0];
        end else if (!diff1[SW-1]) begin
            r_next = diff1[MOD_BITS-1:0];
        end else begin
            r_next = sum[MOD_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (busy_reg) begin
                r_reg   <= r_next;
                a_reg   <= a_reg << 1;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end else if (start) begin
                a_reg    <= op_a;
                b_reg    <= op_b;
                m_reg    <= op_m;
                r_reg    <= '0;
                cnt_reg  <= CW'(MOD_BITS);
                busy_reg <= 1'b1;
            end
        end
    end

    assign result         = r_reg;
    assign mm_status.busy = busy_reg;
    assign mm_status.done = done_reg;

endmodule

[tb/modular_exponentiation_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Watches both stream channels, computes the residue for every accepted
// request and compares each returned result, in order, against it.
// ----------------------------------------------------------------------------
module modular_exponentiation_checker #(
    parameter int MOD_BITS = 31,
    parameter int EXP_BITS = 63
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    input  logic                                      s_tready,
    input  logic [((2*MOD_BITS+EXP_BITS+7)/8)*8-1:0]  s_tdata,
    input  logic                                      m_tvalid,
    input  logic                                      m_tready,
    input  logic [((MOD_BITS+7)/8)*8-1:0]             m_tdata,
    output int                                        fail_count,
    output int                                        pending_count,
    output int                                        result_count
);

    logic [MOD_BITS-1:0] residue_q[$];

    function automatic logic [MOD_BITS-1:0] expected_power_residue(
        input logic [MOD_BITS-1:0] base_v,
        input logic [EXP_BITS-1:0] expo_v,
        input logic [MOD_BITS-1:0] mod_v
    );
        logic [63:0] acc;
        logic [63:0] pw;
        logic [63:0] m64;
        int          i;
        if (mod_v == '0) begin
            return '0;
        end
        m64 = 64'(mod_v);
        acc = 64'd1 % m64;
        pw  = 64'(base_v) % m64;
        // right-to-left scan: multiply in where the bit is set, square always
        for (i = 0; i < EXP_BITS; i++) begin
            if (expo_v[i]) begin
                acc = (acc * pw) % m64;
            end
            pw = (pw * pw) % m64;
        end
        return acc[MOD_BITS-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [MOD_BITS-1:0] want;
        logic [MOD_BITS-1:0] got;
        if (!aresetn) begin
            residue_q.delete();
            fail_count    <= 0;
            pending_count <= 0;
            result_count  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                residue_q = {residue_q, expected_power_residue(
                    s_tdata[MOD_BITS-1:0],
                    s_tdata[MOD_BITS +: EXP_BITS],
                    s_tdata[MOD_BITS+EXP_BITS +: MOD_BITS])};
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[MOD_BITS-1:0];
                result_count <= result_count + 1;
                if (residue_q.size() == 0) begin
                    $error("unexpected result: power_residue %0d with no request pending",
                           got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = residue_q.pop_front();
                    if (got !== want) begin
                        $error("power_residue mismatch: expected %0d, actual %0d", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= residue_q.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives directed corner requests then a random mix of bases, exponents and
// moduli, with random gaps on the request side and random result back-pressure.
// ----------------------------------------------------------------------------
module tb;

    localparam int MOD_BITS   = 31;
    localparam int EXP_BITS   = 63;
    localparam int S_W        = ((2*MOD_BITS+EXP_BITS+7)/8)*8;
    localparam int M_W        = ((MOD_BITS+7)/8)*8;
    localparam int RAND_COUNT = 121;
    localparam int IDLE_LIMIT = 20000;

    localparam logic [MOD_BITS-1:0] MOD_MAX = {MOD_BITS{1'b1}};
    localparam logic [EXP_BITS-1:0] EXP_MAX = {EXP_BITS{1'b1}};

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    int fail_count;
    int pending_count;
    int result_count;
    int sent_count = 0;
    int directed_count = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit sink_quiet = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    modular_exponentiation #(
        .MOD_BITS(MOD_BITS),
        .EXP_BITS(EXP_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    modular_exponentiation_checker #(
        .MOD_BITS(MOD_BITS),
        .EXP_BITS(EXP_BITS)
    ) checker_i (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .fail_count(fail_count),
        .pending_count(pending_count),
        .result_count(result_count)
    );

    // mostly short, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 200);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(
        input logic [MOD_BITS-1:0] base_v,
        input logic [EXP_BITS-1:0] expo_v,
        input logic [MOD_BITS-1:0] mod_v,
        input int                  gap
    );
        logic [S_W-1:0] word;
        word = '0;
        word[MOD_BITS-1:0]                     = base_v;
        word[MOD_BITS +: EXP_BITS]             = expo_v;
        word[MOD_BITS+EXP_BITS +: MOD_BITS]    = mod_v;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic send_directed(
        input logic [MOD_BITS-1:0] base_v,
        input logic [EXP_BITS-1:0] expo_v,
        input logic [MOD_BITS-1:0] mod_v
    );
        send_request(base_v, expo_v, mod_v, idle_gap());
        directed_count++;
    endtask

    // result back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!sink_quiet && $urandom_range(0, 9) < 3) begin
                stall_left <= idle_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            sink_quiet <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [MOD_BITS-1:0] base_v;
        logic [EXP_BITS-1:0] expo_v;
        logic [MOD_BITS-1:0] mod_v;
        logic [63:0]         raw;
        int                  len;
        int                  r;
        bit                  steady;
        int                  n;

        steady = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed corners
        send_directed(31'd0, 63'd0, 31'd1);
        send_directed(31'd5, 63'd0, 31'd7);
        send_directed(31'd0, 63'd5, 31'd13);
        send_directed(31'd9, 63'd9, 31'd0);
        send_directed(MOD_MAX, EXP_MAX, MOD_MAX);
        send_directed(MOD_MAX, EXP_MAX, MOD_MAX - 31'd1);
        send_directed(MOD_MAX, EXP_MAX, 31'd1);
        send_directed(31'd1, EXP_MAX, MOD_MAX);
        send_directed(31'd2, 63'd30, MOD_MAX);
        send_directed(31'd2, 63'(MOD_MAX - 31'd1), MOD_MAX);
        send_directed(31'd3, 63'd1, 31'd2);
        send_directed(31'd7, EXP_MAX, 31'd2);
        send_directed(31'd12345, 63'd1, 31'd100);
        send_directed(MOD_MAX - 31'd1, 63'd2, MOD_MAX);
        send_directed(31'd123, 63'h4000_0000_0000_0000, 31'd1000003);
        send_directed(31'h4000_0000, 63'h5555_5555_5555_5555, 31'h4000_0001);
        send_directed(31'h2aaa_aaaa, 63'h2aaa_aaaa_aaaa_aaaa, 31'h5555_5555);
        send_directed(31'h7fff_0000, 63'd1, 31'h4000_0000);
        send_directed(31'd0, 63'd0, MOD_MAX);

        // random mix, small exponents favoured to keep run length down
        for (n = 0; n < RAND_COUNT; n++) begin
            if (n % 16 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 19);
            if (r == 0) begin
                mod_v = 31'd1;
            end else if (r < 5) begin
                mod_v = MOD_BITS'($urandom_range(2, 255));
            end else if (r < 9) begin
                mod_v = MOD_MAX - MOD_BITS'($urandom_range(0, 1000));
            end else if (r < 11) begin
                mod_v = MOD_BITS'(1) << $urandom_range(1, MOD_BITS - 1);
            end else begin
                mod_v = MOD_BITS'($urandom_range(1, 32'h7fff_ffff));
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                base_v = '0;
            end else if (r == 1) begin
                base_v = mod_v;
            end else if (r == 2) begin
                base_v = MOD_MAX;
            end else begin
                base_v = MOD_BITS'($urandom);
            end
            raw = {$urandom, $urandom};
            if ($urandom_range(0, 2) == 0) begin
                expo_v = EXP_BITS'(raw);
            end else begin
                len = $urandom_range(0, 40);
                expo_v = (len == 0) ? '0 : EXP_BITS'(raw >> (64 - len));
            end
            send_request(base_v, expo_v, mod_v, steady ? 0 : idle_gap());
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("sent %0d requests (%0d directed corners, %0d random), %0d results checked",
                 sent_count, directed_count, sent_count - directed_count, result_count);
        $display("random part mixed tiny, power-of-two and near-maximum moduli");
        $display("with exponents up to 63 bits");
        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
